// ===== hdl/rdq_pkg.sv =====
// Package: shared constants, codes and control/status types for the deque engine.
`timescale 1ns / 1ps
package rdq_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int CMD_W  = 3;
   localparam int DATA_W = 16;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DRAIN   = 3'd4;

   localparam logic [STAT_W-1:0] ST_ELEMENT = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_ERROR   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic do_clear;
      logic do_push;
      logic do_reverse;
      logic do_discard;
      logic rd_start;     // read first element of a drain
      logic rd_next;      // read following element
      logic load_flag;    // load empty/error result
      logic load_elem;    // load element result from read register
   } rdq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;
      logic failed;
      logic idx_last;
      logic out_free;
   } rdq_stat_type;

endpackage

// ===== hdl/rdq_ctrl.sv =====
// Controller: command decode and drain sequencing state machine.
`timescale 1ns / 1ps
module rdq_ctrl
   import rdq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  rdq_stat_type       stat,
   output rdq_cmd_type        cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FLAG = 2'd1;
   localparam logic [1:0] S_ELEM = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_CLEAR:   cmd.do_clear   = 1'b1;
                  CMD_PUSH:    cmd.do_push    = 1'b1;
                  CMD_REVERSE: cmd.do_reverse = 1'b1;
                  CMD_DISCARD: cmd.do_discard = 1'b1;
                  CMD_DRAIN: begin
                     if (stat.failed || stat.count_zero) begin
                        state_in = S_FLAG;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = S_ELEM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FLAG: begin
            if (stat.out_free) begin
               cmd.load_flag = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ELEM: begin
            if (stat.out_free) begin
               cmd.load_elem = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/rdq_datapath.sv =====
// Datapath: element memory, ring pointers, flags, drain index and result register.
`timescale 1ns / 1ps
module rdq_datapath
   import rdq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  rdq_cmd_type        cmd,
   output rdq_stat_type       stat,
   input  logic [DATA_W-1:0]  req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [DATA_W-1:0]  rsp_element,
   output logic               rsp_last
);

   localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rev_ff, rev_in;
   logic              failed_ff, failed_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] out_status_ff;
   logic [DATA_W-1:0] out_element_ff;
   logic              out_last_ff;

   logic [ADDR_W-1:0] rd_idx;
   logic [CNT_W-1:0]  rd_off;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] head_inc;
   logic              rd_en;

   // (base + offset) mod DEPTH with offset < DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign rd_en    = cmd.rd_start || cmd.rd_next;
   assign rd_idx   = cmd.rd_start ? '0 : idx_ff + 1'b1;
   assign rd_off   = rev_ff ? (count_ff - 1'b1 - CNT_W'(rd_idx)) : CNT_W'(rd_idx);
   assign rd_addr  = wrap_add(head_ff, rd_off[ADDR_W-1:0]);
   assign wr_addr  = wrap_add(head_ff, count_ff[ADDR_W-1:0]);
   assign head_inc = wrap_add(head_ff, ADDR_W'(1));

   assign stat.count_zero = (count_ff == '0);
   assign stat.failed     = failed_ff;
   assign stat.idx_last   = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      failed_in = failed_ff;
      idx_in    = idx_ff;
      if (cmd.do_clear) begin
         head_in   = '0;
         count_in  = '0;
         rev_in    = 1'b0;
         failed_in = 1'b0;
      end
      if (cmd.do_push && (count_ff < CNT_W'(DEPTH))) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.do_reverse) begin
         rev_in = !rev_ff;
      end
      if (cmd.do_discard) begin
         if (count_ff == '0) begin
            failed_in = 1'b1;
         end else begin
            if (!rev_ff) begin
               head_in = head_inc;
            end
            count_in = count_ff - 1'b1;
         end
      end
      if (rd_en) begin
         idx_in = rd_idx;
      end
      // last element handed to the result register empties the store
      if (cmd.load_elem && stat.idx_last) begin
         head_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         rev_ff    <= 1'b0;
         failed_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         rev_ff    <= rev_in;
         failed_ff <= failed_in;
         idx_ff    <= idx_in;
      end
   end

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_push && (count_ff < CNT_W'(DEPTH))) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_flag || cmd.load_elem) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_flag) begin
         out_status_ff  <= failed_ff ? ST_ERROR : ST_EMPTY;
         out_element_ff <= '0;
         out_last_ff    <= 1'b1;
      end else if (cmd.load_elem) begin
         out_status_ff  <= ST_ELEMENT;
         out_element_ff <= rd_data_ff;
         out_last_ff    <= stat.idx_last;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_element = out_element_ff;
   assign rsp_last    = out_last_ff;

endmodule

// ===== hdl/reversible_deque_engine.sv =====
// Top level: ring-buffer deque with lazy reverse, controller plus datapath.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_command[2:0], req_value[15:0]
//   rsp_      out        rsp_valid / rsp_ready   rsp_status[1:0], rsp_element[15:0], rsp_last
//
// Clear, push, reverse, discard and unused codes leave the controller idle.
// A drain first reads the first element into the read register, then loads one
// result per cycle while the result register is free (rsp_ready high), limited by
// the single memory read port feeding the read register; an empty or error drain loads one flag result.
// req_ready is low for the whole drain; a stalled rsp_ready holds the result
// register and the sequencer in place.
// reset is synchronous, active high; the element memory is not cleared.
`timescale 1ns / 1ps
module reversible_deque_engine
   import rdq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [DATA_W-1:0]  req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [DATA_W-1:0]  rsp_element,
   output logic               rsp_last
);

   rdq_cmd_type  cmd;
   rdq_stat_type stat;

   // decodes each transaction and steps the drain
   rdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd)
   );

   // storage, pointers, flags and the result register
   rdq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== verif/reversible_deque_engine_test.sv =====
// Self-checking testbench for the reversible deque engine.
`timescale 1ns / 1ps
module reversible_deque_engine_test
   import rdq_pkg::*;
();

   localparam int ITEM_TARGET = 270;     // counted items (ignored opcodes excluded)
   localparam int CYCLE_LIMIT = 400000;  // generous watchdog
   localparam int TAIL_CYCLES = 12;      // quiet time after the last result
   localparam int SHOW_LIMIT  = 10;      // mismatches printed in full

   // Opcodes 5..7 are undefined; the engine must ignore them.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MD = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // One request transaction as queued for the driver. wait_idle makes the
   // driver hold off until every outstanding drain result has come back.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd_code;
      logic [DATA_W-1:0] payload;
      logic              wait_idle;
   } host_txn_type;

   // One response transaction.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] element;
      logic              last;
   } drain_word_type;

   // ---------------------------------------------------------------------
   // Clock, reset and DUT ports (all inputs known from time zero)
   // ---------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command = '0;
   logic [DATA_W-1:0] req_value   = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_element;
   logic              rsp_last;

   always #5 clock = ~clock;

   reversible_deque_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the deque, updated on every accepted request
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0] shadow_store [DEPTH];
   logic [ADDR_W-1:0] shadow_head     = '0;
   logic [CNT_W-1:0]  shadow_count    = '0;
   logic              shadow_reversed = 1'b0;
   logic              shadow_failed   = 1'b0;

   drain_word_type drain_words_due [$];   // results owed by the engine, oldest first
   host_txn_type   pending_txns [$];      // stimulus not yet presented
   int             gen_total      = 0;
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   logic           req_taken      = 1'b0; // request accepted at the last rising edge

   function automatic logic [ADDR_W-1:0] ring_slot(input int offset);
      return ADDR_W'((int'(shadow_head) + offset) % DEPTH);
   endfunction

   // Apply one command to the shadow deque and queue whatever a drain owes.
   task automatic mirror_command(input logic [CMD_W-1:0] cmd,
                                 input logic [DATA_W-1:0] val);
      drain_word_type w;
      int             n;
      int             off;
      case (cmd)
         CMD_CLEAR: begin
            shadow_head     = '0;
            shadow_count    = '0;
            shadow_reversed = 1'b0;
            shadow_failed   = 1'b0;
         end
         CMD_PUSH: begin
            // full store: value silently dropped
            if (int'(shadow_count) < DEPTH) begin
               shadow_store[ring_slot(int'(shadow_count))] = val;
               shadow_count = shadow_count + 1'b1;
            end
         end
         CMD_REVERSE: begin
            shadow_reversed = ~shadow_reversed;
         end
         CMD_DISCARD: begin
            if (shadow_count == 0) begin
               shadow_failed = 1'b1;   // sticky until clear
            end else begin
               // reversed: logical front is the physical back, head stays put
               if (!shadow_reversed) shadow_head = ring_slot(1);
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_DRAIN: begin
            if (shadow_failed) begin
               w = '{status: ST_ERROR, element: '0, last: 1'b1};
               drain_words_due = {drain_words_due, w};
            end else if (shadow_count == 0) begin
               w = '{status: ST_EMPTY, element: '0, last: 1'b1};
               drain_words_due = {drain_words_due, w};
            end else begin
               n = int'(shadow_count);
               for (int i = 0; i < n; i++) begin
                  off = shadow_reversed ? (n - 1 - i) : i;
                  w.status  = ST_ELEMENT;
                  w.element = shadow_store[ring_slot(off)];
                  w.last    = (i == n - 1);
                  drain_words_due = {drain_words_due, w};
               end
               // orientation survives the drain
               shadow_count = '0;
               shadow_head  = '0;
            end
         end
         default: begin
            // spare opcodes: no effect
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Monitor: track request acceptance, check every response transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      drain_word_type got;
      drain_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) mirror_command(req_command, req_value);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_element, rsp_last};
            if (drain_words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("%0t: unexpected result status %0d element %h last %b",
                           $realtime, got.status, got.element, got.last);
            end else begin
               want = drain_words_due[0];
               drain_words_due.delete(0);
               if (got.status !== want.status || got.element !== want.element ||
                   got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_LIMIT)
                     $display({"%0t: mismatch: expected status %0d element %h last %b,",
                               " got status %0d element %h last %b"},
                              $realtime, want.status, want.element, want.last,
                              got.status, got.element, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of requests separated by random gaps. Inputs move on
   // the falling edge; a presented request is held until it is taken.
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_requests
      host_txn_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // still waiting for the handshake, keep everything stable
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_txns.size() == 0 ||
                   (pending_txns[0].wait_idle && drain_words_due.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         nxt = pending_txns[0];
         pending_txns.delete(0);
         req_valid   <= 1'b1;
         req_command <= nxt.cmd_code;
         req_value   <= nxt.payload;
         burst_left = burst_left - 1;
         if (burst_left <= 0) begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response backpressure: ready follows a randomly picked mode - always
   // ready, random stalls, or a repeating 8-bit ready pattern.
   // ---------------------------------------------------------------------
   int         ready_mode  = 0;
   int         ready_phase = 0;
   logic [7:0] ready_mask  = 8'hFF;

   always @(negedge clock) begin : drive_ready
      if (ready_phase % 48 == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_mask = 8'($urandom_range(0, 255)) | 8'h01;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) < 6);
         default: rsp_ready <= ready_mask[ready_phase % 8];
      endcase
      ready_phase = ready_phase + 1;
   end

   // Watchdog.
   always @(posedge clock) begin : watchdog
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, drain_words_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic queue_txn(input logic [CMD_W-1:0] cmd,
                            input logic [DATA_W-1:0] val,
                            input logic hold = 1'b0);
      host_txn_type t;
      t.cmd_code  = cmd;
      t.payload   = val;
      t.wait_idle = hold;
      pending_txns = {pending_txns, t};
      if (cmd <= CMD_DRAIN) gen_total++;   // ignored opcodes are not counted
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Fill to capacity, overflow, walk the head forward, wrap the ring,
   // then reverse and drain the whole 62-entry content.
   task automatic queue_fill_and_wrap();
      queue_txn(CMD_CLEAR, pick_value());
      for (int i = 0; i < DEPTH; i++) queue_txn(CMD_PUSH, pick_value());
      queue_txn(CMD_PUSH, 16'hDEAD);   // dropped: store full
      queue_txn(CMD_PUSH, 16'hBEEF);   // dropped: store full
      for (int i = 0; i < 5; i++) queue_txn(CMD_DISCARD, pick_value());
      for (int i = 0; i < 5; i++) queue_txn(CMD_PUSH, pick_value());  // wraps past slot 63
      queue_txn(CMD_REVERSE, pick_value());
      queue_txn(CMD_DISCARD, pick_value());
      queue_txn(CMD_DISCARD, pick_value());
      queue_txn(CMD_DRAIN, pick_value());
   endtask

   initial begin : run_test
      int   n;
      logic did_fill;
      did_fill = 1'b0;

      // Directed: empty drain, sticky error, orientation, both discard ends,
      // field extremes, spare opcodes.
      queue_txn(CMD_CLEAR,   16'h0000);
      queue_txn(CMD_DRAIN,   16'hFFFF);          // empty store
      queue_txn(CMD_DISCARD, 16'h0000);          // discard on empty -> error
      queue_txn(CMD_DRAIN,   16'h0000);          // error result
      queue_txn(CMD_PUSH,    16'h0000, 1'b1);    // sender waits for idle here
      queue_txn(CMD_DRAIN,   16'h0000);          // error is sticky
      queue_txn(CMD_CLEAR,   16'hFFFF);
      queue_txn(CMD_PUSH,    16'h0000);
      queue_txn(CMD_PUSH,    16'hFFFF);
      queue_txn(CMD_PUSH,    16'h5A5A);
      queue_txn(CMD_REVERSE, 16'h0000);
      queue_txn(CMD_DRAIN,   16'h0000);          // reverse order, orientation kept
      queue_txn(CMD_PUSH,    16'h1111);
      queue_txn(CMD_PUSH,    16'h2222);
      queue_txn(CMD_PUSH,    16'h3333);
      queue_txn(CMD_DISCARD, 16'h0000);          // reversed: drops physical back
      queue_txn(CMD_REVERSE, 16'h0000);
      queue_txn(CMD_DISCARD, 16'h0000);          // forward: head advances
      queue_txn(CMD_DRAIN,   16'h0000);
      queue_txn(CMD_SPARE_LO, 16'hAAAA);
      queue_txn(CMD_SPARE_MD, 16'h5555);
      queue_txn(CMD_SPARE_HI, 16'hFFFF);
      queue_txn(CMD_DRAIN,   16'h0000, 1'b1);    // empty, after a full idle
      queue_txn(CMD_CLEAR,   16'h0000);

      // Random: mostly push runs with interleaved reverse/discard ending in
      // a drain; some error sequences and some raw noise.
      while (gen_total < ITEM_TARGET) begin
         if (!did_fill && gen_total > 60) begin
            queue_fill_and_wrap();
            did_fill = 1'b1;
         end
         case ($urandom_range(0, 9))
            0: begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++)
                  queue_txn(CMD_W'($urandom_range(0, 7)), pick_value());
            end
            1: begin
               queue_txn(CMD_CLEAR, pick_value(), $urandom_range(0, 3) == 0);
               queue_txn(CMD_DISCARD, pick_value());
               queue_txn(CMD_PUSH, pick_value());
               queue_txn(CMD_DRAIN, pick_value());
               queue_txn(CMD_CLEAR, pick_value());
            end
            default: begin
               if ($urandom_range(0, 2) == 0)
                  queue_txn(CMD_CLEAR, pick_value(), $urandom_range(0, 9) == 0);
               n = $urandom_range(1, 12);
               for (int i = 0; i < n; i++) begin
                  queue_txn(CMD_PUSH, pick_value(), i == 0 && $urandom_range(0, 9) == 0);
                  if ($urandom_range(0, 4) == 0) queue_txn(CMD_REVERSE, pick_value());
                  if ($urandom_range(0, 5) == 0) queue_txn(CMD_DISCARD, pick_value());
               end
               queue_txn(CMD_DRAIN, pick_value());
            end
         endcase
      end

      // Reset: held from time zero, released on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and every result is back.
      while (pending_txns.size() != 0 || req_valid || drain_words_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (drain_words_due.size() != 0)
         $display("%0d expected results never arrived", drain_words_due.size());
      if (mismatch_count > SHOW_LIMIT)
         $display("%0d mismatches in total", mismatch_count);
      if (mismatch_count == 0 && drain_words_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rdq_pkg.sv
hdl/rdq_ctrl.sv
hdl/rdq_datapath.sv
hdl/reversible_deque_engine.sv
verif/reversible_deque_engine_test.sv
